// ===== rtl/lcdseq_pkg.sv =====
package lcdseq_pkg;

  // Default request queue depth
  localparam int QueueDepthDefault = 8;

  // Request kinds, carried on s_tuser
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_POSITION = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FOUR_BIT_BUS      = 3'd0,
    REG_TALL_FONT         = 3'd1,
    REG_TWO_LINE_MODE     = 3'd2,
    REG_DISPLAY_ENABLE    = 3'd3,
    REG_CURSOR_VISIBLE    = 3'd4,
    REG_CURSOR_BLINK      = 3'd5,
    REG_ADDRESS_INCREMENT = 3'd6,
    REG_DISPLAY_SHIFT     = 3'd7
  } cfg_reg_t;

  // Display command bytes
  localparam logic [7:0] LCD_FOUR_BIT_SELECT = 8'h02;
  localparam logic [7:0] LCD_FUNC_8BIT       = 8'h30;
  localparam logic [7:0] LCD_FUNC_4BIT       = 8'h20;
  localparam logic [7:0] LCD_DISPLAY_CTRL    = 8'h08;
  localparam logic [7:0] LCD_CLEAR           = 8'h01;
  localparam logic [7:0] LCD_ENTRY_MODE      = 8'h04;
  localparam logic [7:0] LCD_SET_ADDRESS     = 8'h80;
  localparam logic [7:0] LCD_LINE1_OFFSET    = 8'h40;

  // Power-up sequence lengths in bytes
  localparam logic [2:0] INIT_LEN_8BIT = 3'd4;
  localparam logic [2:0] INIT_LEN_4BIT = 3'd5;

  typedef struct packed {
    logic four_bit_bus;
    logic tall_font;
    logic two_line_mode;
    logic display_enable;
    logic cursor_visible;
    logic cursor_blink;
    logic address_increment;
    logic display_shift;
  } display_cfg_t;

  // One queued request
  typedef struct packed {
    cmd_t       kind;
    logic       last;
    logic [7:0] payload;
  } queue_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // Command byte for a given step of the power-up sequence
  function automatic logic [7:0] init_command(logic [2:0] step, display_cfg_t cfg);
    logic [2:0] idx;
    logic [7:0] value;
    idx = cfg.four_bit_bus ? step - 3'd1 : step;
    case (idx)
      3'd0: value = (cfg.four_bit_bus ? LCD_FUNC_4BIT : LCD_FUNC_8BIT)
                    | {4'b0, cfg.two_line_mode, cfg.tall_font, 2'b0};
      3'd1: value = LCD_DISPLAY_CTRL
                    | {5'b0, cfg.display_enable, cfg.cursor_visible, cfg.cursor_blink};
      3'd2: value = LCD_CLEAR;
      default: value = LCD_ENTRY_MODE
                    | {6'b0, cfg.address_increment, cfg.display_shift};
    endcase
    if (cfg.four_bit_bus && step == 3'd0) begin
      value = LCD_FOUR_BIT_SELECT;
    end
    return value;
  endfunction

endpackage

// ===== rtl/lcdseq_queue.sv =====
module lcdseq_queue #(
  parameter int QUEUE_DEPTH = lcdseq_pkg::QueueDepthDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lcdseq_pkg::queue_ctrl_t    ctrl,
  input  lcdseq_pkg::queue_entry_t   wr_entry,
  output lcdseq_pkg::queue_entry_t   head_entry,
  output lcdseq_pkg::queue_status_t  status
);
  import lcdseq_pkg::*;

  localparam int AddrWidth  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AddrWidth-1:0]  LastAddr = AddrWidth'(QUEUE_DEPTH - 1);
  localparam logic [CountWidth-1:0] FullCount = CountWidth'(QUEUE_DEPTH);

  queue_entry_t            mem [QUEUE_DEPTH];
  logic [AddrWidth-1:0]    head;
  logic [AddrWidth-1:0]    head_next;
  logic [AddrWidth-1:0]    tail;
  logic [CountWidth-1:0]   count;

  assign status.empty = (count == '0);
  assign status.full  = (count == FullCount);

  // Address the head will hold after this cycle
  always_comb begin
    head_next = head;
    if (ctrl.pop) begin
      head_next = (head == LastAddr) ? '0 : head + 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (ctrl.push) begin
        tail <= (tail == LastAddr) ? '0 : tail + 1'b1;
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage with registered head read, write-first when the queue is refilled
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= wr_entry;
    end
    if (ctrl.push && tail == head_next) begin
      head_entry <= wr_entry;
    end else begin
      head_entry <= mem[head_next];
    end
  end

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |-> !status.full) else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> !status.empty) else $error("queue pop while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FullCount) else $error("queue count beyond depth");

endmodule

// ===== rtl/char_lcd_command_sequencer.sv =====
// Character LCD command sequencer.
// Input stream (s_*): one transaction per item. s_tuser holds the kind: a tick
// advances the display bus by at most one enable phase; write character, clear and
// set position are requests that go into a FIFO of QUEUE_DEPTH entries.
// Output stream (m_*): exactly one result per input item, carrying the pin
// levels after that item, init_done, and request_accepted / request_done.
// One item is taken every cycle while s_tready is high, the whole update being
// a single registered pass. A full queue rejects requests (accepted = 0).
// At reset the pins go low, the queue empties and configuration takes its
// default values; the following ticks send the power-up command sequence
// (four or five bytes), after which init_done is high and queued requests
// are served. A byte takes two ticks on an 8-bit bus and four in 4-bit mode.
// While the receiver holds m_tready low the result waits in the output register and
// s_tready drops; no item is taken until it is passed on. Configuration is written
// via cfg_we/cfg_addr/cfg_data; the user must do so only while idle, unchecked.
module char_lcd_command_sequencer #(
  parameter int QUEUE_DEPTH = lcdseq_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // char_code[7:0], line_select[8], column[14:9]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // pin_enable[0], pin_register_select[1],
                                 // pin_read_write[2], pin_data[10:3], init_done[11],
                                 // request_accepted[12], request_done[13]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic        cfg_data
);
  import lcdseq_pkg::*;

  // Configuration
  display_cfg_t cfg;

  // Sequencer state
  logic [2:0] init_step;
  logic       operating;
  logic       low_nibble_next;
  logic       home_pending;
  logic       pin_enable;        // also marks the high phase of the strobe
  logic       pin_rs;
  logic [7:0] pin_data;

  logic [2:0] init_step_next;
  logic       operating_next;
  logic       low_nibble_next_next;
  logic       home_pending_next;
  logic       pin_enable_next;
  logic       pin_rs_next;
  logic [7:0] pin_data_next;

  logic          in_fire;
  cmd_t          in_cmd;
  logic          accepted;
  logic          done;
  logic          phase_go;
  logic [7:0]    phase_value;
  logic          phase_rs;
  logic          byte_end;
  logic [2:0]    init_total;
  queue_ctrl_t   qctrl;
  queue_entry_t  wr_entry;
  queue_entry_t  head_entry;
  queue_status_t qstat;

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign in_cmd   = cmd_t'(s_tuser);

  // Request entry built from the input fields
  always_comb begin
    wr_entry.kind = in_cmd;
    wr_entry.last = s_tlast;
    case (in_cmd)
      CMD_WRITE:    wr_entry.payload = s_tdata[7:0];
      CMD_POSITION: wr_entry.payload = LCD_SET_ADDRESS + {2'b0, s_tdata[14:9]}
                                       + (s_tdata[8] ? LCD_LINE1_OFFSET : 8'h00);
      default:      wr_entry.payload = 8'h00;
    endcase
  end

  lcdseq_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (qctrl),
    .wr_entry   (wr_entry),
    .head_entry (head_entry),
    .status     (qstat)
  );

  assign init_total = cfg.four_bit_bus ? INIT_LEN_4BIT : INIT_LEN_8BIT;
  // Low phase that completes the byte
  assign byte_end   = pin_enable && !(cfg.four_bit_bus && !low_nibble_next);

  // Next-state logic for one item
  always_comb begin
    init_step_next       = init_step;
    operating_next       = operating;
    low_nibble_next_next = low_nibble_next;
    home_pending_next    = home_pending;
    pin_enable_next      = pin_enable;
    pin_rs_next          = pin_rs;
    pin_data_next        = pin_data;
    accepted             = 1'b0;
    done                 = 1'b0;
    phase_go             = 1'b0;
    phase_value          = LCD_CLEAR;
    phase_rs             = 1'b0;
    qctrl                = '0;

    if (in_fire && !rst) begin
      if (in_cmd == CMD_TICK) begin
        if (!operating) begin
          // Power-up sequence
          if (init_step >= init_total) begin
            operating_next = 1'b1;
            init_step_next = '0;
          end else begin
            phase_go    = 1'b1;
            phase_value = init_command(init_step, cfg);
            if (byte_end) begin
              if (init_step + 3'd1 >= init_total) begin
                operating_next = 1'b1;
                init_step_next = '0;
              end else begin
                init_step_next = init_step + 3'd1;
              end
            end
          end
        end else if (home_pending) begin
          // Cursor home after a clear
          phase_go    = 1'b1;
          phase_value = LCD_SET_ADDRESS;
          if (byte_end) begin
            home_pending_next = 1'b0;
          end
        end else if (!qstat.empty) begin
          phase_go = 1'b1;
          unique case (head_entry.kind)
            CMD_WRITE: begin
              phase_value = head_entry.payload;
              phase_rs    = 1'b1;
            end
            CMD_CLEAR: phase_value = LCD_CLEAR;
            default:   phase_value = head_entry.payload;
          endcase
          if (byte_end) begin
            qctrl.pop = 1'b1;
            if (head_entry.kind == CMD_CLEAR) begin
              home_pending_next = 1'b1;
            end
            done = (head_entry.kind == CMD_WRITE) ? head_entry.last : 1'b1;
          end
        end
      end else begin
        accepted   = !qstat.full;
        qctrl.push = !qstat.full;
      end
    end

    // One enable phase on the bus
    if (phase_go) begin
      if (!pin_enable) begin
        if (cfg.four_bit_bus) begin
          pin_data_next = {4'b0, low_nibble_next ? phase_value[3:0] : phase_value[7:4]};
        end else begin
          pin_data_next = phase_value;
        end
        pin_enable_next = 1'b1;
        pin_rs_next     = phase_rs;
      end else begin
        pin_enable_next      = 1'b0;
        low_nibble_next_next = cfg.four_bit_bus && !low_nibble_next;
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      init_step       <= '0;
      operating       <= 1'b0;
      low_nibble_next <= 1'b0;
      home_pending    <= 1'b0;
      pin_enable      <= 1'b0;
      pin_rs          <= 1'b0;
      pin_data        <= '0;
    end else begin
      init_step       <= init_step_next;
      operating       <= operating_next;
      low_nibble_next <= low_nibble_next_next;
      home_pending    <= home_pending_next;
      pin_enable      <= pin_enable_next;
      pin_rs          <= pin_rs_next;
      pin_data        <= pin_data_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (in_fire) begin
      m_tdata <= {2'b0, done, accepted, operating_next, pin_data_next, 1'b0,
                  pin_rs_next, pin_enable_next};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{four_bit_bus: 1'b0, tall_font: 1'b0, two_line_mode: 1'b1,
               display_enable: 1'b1, cursor_visible: 1'b0, cursor_blink: 1'b0,
               address_increment: 1'b1, display_shift: 1'b0};
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_FOUR_BIT_BUS:      cfg.four_bit_bus      <= cfg_data;
        REG_TALL_FONT:         cfg.tall_font         <= cfg_data;
        REG_TWO_LINE_MODE:     cfg.two_line_mode     <= cfg_data;
        REG_DISPLAY_ENABLE:    cfg.display_enable    <= cfg_data;
        REG_CURSOR_VISIBLE:    cfg.cursor_visible    <= cfg_data;
        REG_CURSOR_BLINK:      cfg.cursor_blink      <= cfg_data;
        REG_ADDRESS_INCREMENT: cfg.address_increment <= cfg_data;
        REG_DISPLAY_SHIFT:     cfg.display_shift     <= cfg_data;
        default: ;
      endcase
    end
  end

  a_request_holds_bus: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_cmd != CMD_TICK |=> $stable(pin_enable) && $stable(pin_data))
    else $error("request transaction moved the bus");

  a_done_when_operating: assert property (@(posedge clk) disable iff (rst)
    done |-> operating) else $error("done raised during power-up");

  a_operating_sticks: assert property (@(posedge clk) disable iff (rst)
    operating |=> operating) else $error("init_done fell without reset");

  a_home_after_clear: assert property (@(posedge clk) disable iff (rst)
    home_pending |-> operating) else $error("cursor home pending during power-up");

endmodule

// ===== tb/tb.sv =====
module tb;
  import lcdseq_pkg::*;

  localparam int FIFO_DEPTH  = QueueDepthDefault;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // One input transaction as the stimulus sees it
  typedef struct {
    cmd_t       cmd;
    logic [7:0] char_code;
    logic       last;
    logic       line_sel;
    logic [5:0] column;
  } bus_item_t;

  // Result fields, laid out as m_tdata[13:0]
  typedef struct packed {
    logic       done;
    logic       accepted;
    logic       init_done;
    logic [7:0] data;
    logic       rw;
    logic       rs;
    logic       en;
  } pin_result_t;

  // A request waiting in the predicted FIFO
  typedef struct {
    cmd_t       kind;
    logic       last;
    logic [7:0] payload;
  } lcd_request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_TICK;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = REG_FOUR_BIT_BUS;
  logic        cfg_data = 1'b0;

  char_lcd_command_sequencer #(.QUEUE_DEPTH(FIFO_DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Predictor state: configuration shadow and bus sequencer
  display_cfg_t shadow_cfg = '{four_bit_bus: 1'b0, tall_font: 1'b0, two_line_mode: 1'b1,
                               display_enable: 1'b1, cursor_visible: 1'b0,
                               cursor_blink: 1'b0, address_increment: 1'b1,
                               display_shift: 1'b0};
  int unsigned  boot_step = 0;
  bit           running = 1'b0;
  bit           strobe_on = 1'b0;
  bit           second_nibble = 1'b0;
  bit           home_due = 1'b0;
  lcd_request_t request_fifo[$];
  logic [7:0]   bus_data = '0;
  logic         bus_en = 1'b0;
  logic         bus_rs = 1'b0;

  bus_item_t    item_backlog[$];
  pin_result_t  expected_pins[$];
  bus_item_t    on_bus;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_total = 0;
  int hold_spent = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int req_taken = 0;
  int req_refused = 0;
  int done_pulses = 0;

  // One enable phase of a byte; returns 1 once the whole byte is out
  function automatic bit drive_phase(logic [7:0] value, logic rs);
    if (!strobe_on) begin
      if (shadow_cfg.four_bit_bus) begin
        bus_data = second_nibble ? {4'h0, value[3:0]} : {4'h0, value[7:4]};
      end else begin
        bus_data = value;
      end
      bus_en = 1'b1;
      bus_rs = rs;
      strobe_on = 1'b1;
      return 1'b0;
    end
    bus_en = 1'b0;
    strobe_on = 1'b0;
    if (shadow_cfg.four_bit_bus && !second_nibble) begin
      second_nibble = 1'b1;
      return 1'b0;
    end
    second_nibble = 1'b0;
    return 1'b1;
  endfunction

  // Power-up sequence, one phase per tick
  function automatic void boot_tick();
    int unsigned total;
    int unsigned idx;
    logic [7:0]  value;
    total = shadow_cfg.four_bit_bus ? 5 : 4;
    if (boot_step >= total) begin
      running = 1'b1;
      boot_step = 0;
      return;
    end
    if (shadow_cfg.four_bit_bus && boot_step == 0) begin
      value = LCD_FOUR_BIT_SELECT;
    end else begin
      idx = shadow_cfg.four_bit_bus ? boot_step - 1 : boot_step;
      case (idx)
        0: value = (shadow_cfg.four_bit_bus ? LCD_FUNC_4BIT : LCD_FUNC_8BIT)
                   | {4'b0, shadow_cfg.two_line_mode, shadow_cfg.tall_font, 2'b0};
        1: value = LCD_DISPLAY_CTRL | {5'b0, shadow_cfg.display_enable,
                   shadow_cfg.cursor_visible, shadow_cfg.cursor_blink};
        2: value = LCD_CLEAR;
        default: value = LCD_ENTRY_MODE
                   | {6'b0, shadow_cfg.address_increment, shadow_cfg.display_shift};
      endcase
    end
    if (drive_phase(value, 1'b0)) begin
      boot_step++;
      if (boot_step >= total) begin
        running = 1'b1;
        boot_step = 0;
      end
    end
  endfunction

  // Serve the FIFO once ready; returns the done pulse
  function automatic bit serve_tick();
    lcd_request_t head;
    bit           finished;
    if (home_due) begin
      if (drive_phase(LCD_SET_ADDRESS, 1'b0)) home_due = 1'b0;
      return 1'b0;
    end
    if (request_fifo.size() == 0) return 1'b0;
    head = request_fifo[0];
    case (head.kind)
      CMD_WRITE: finished = drive_phase(head.payload, 1'b1);
      CMD_CLEAR: finished = drive_phase(LCD_CLEAR, 1'b0);
      default:   finished = drive_phase(head.payload, 1'b0);
    endcase
    if (!finished) return 1'b0;
    if (head.kind == CMD_CLEAR) home_due = 1'b1;
    void'(request_fifo.pop_front());
    return (head.kind == CMD_WRITE) ? head.last : 1'b1;
  endfunction

  function automatic pin_result_t predict_pins(bus_item_t it);
    pin_result_t  r;
    lcd_request_t req;
    r = '0;
    if (it.cmd == CMD_TICK) begin
      if (!running) boot_tick();
      else r.done = serve_tick();
    end else if (request_fifo.size() < FIFO_DEPTH) begin
      req.kind = it.cmd;
      req.last = it.last;
      case (it.cmd)
        CMD_WRITE:    req.payload = it.char_code;
        CMD_POSITION: req.payload = LCD_SET_ADDRESS + {2'b0, it.column}
                                    + (it.line_sel ? LCD_LINE1_OFFSET : 8'h00);
        default:      req.payload = 8'h00;
      endcase
      request_fifo.push_back(req);
      r.accepted = 1'b1;
    end
    if (it.cmd != CMD_TICK) begin
      if (r.accepted) req_taken++;
      else req_refused++;
    end
    if (r.done) done_pulses++;
    r.en = bus_en;
    r.rs = bus_rs;
    r.rw = 1'b0;
    r.data = bus_data;
    r.init_done = running;
    return r;
  endfunction

  // Input driver: offers backlog items with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_pins.push_back(predict_pins(on_bus));
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = item_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= on_bus.cmd;
          s_tlast <= on_bus.last;
          s_tdata <= {1'b0, on_bus.column, on_bus.line_sel, on_bus.char_code};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: stalls at random, holds off on request, checks each transaction
  always @(posedge clk) begin
    pin_result_t got;
    pin_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[13:0];
      if (expected_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h with nothing outstanding", m_tdata);
      end else begin
        want = expected_pins.pop_front();
        results_checked++;
        if (got.en !== want.en || got.rs !== want.rs || got.rw !== want.rw ||
            got.data !== want.data || got.init_done !== want.init_done ||
            got.accepted !== want.accepted || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch on result %0d:", results_checked);
            $display("  expected en=%b rs=%b rw=%b data=%h init=%b acc=%b done=%b",
                     want.en, want.rs, want.rw, want.data, want.init_done,
                     want.accepted, want.done);
            $display("  got      en=%b rs=%b rw=%b data=%h init=%b acc=%b done=%b",
                     got.en, got.rs, got.rw, got.data, got.init_done,
                     got.accepted, got.done);
          end
        end
      end
    end
    if (hold_spent < hold_total) begin
      hold_spent <= hold_spent + 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    case (idx)
      REG_FOUR_BIT_BUS:      shadow_cfg.four_bit_bus = value;
      REG_TALL_FONT:         shadow_cfg.tall_font = value;
      REG_TWO_LINE_MODE:     shadow_cfg.two_line_mode = value;
      REG_DISPLAY_ENABLE:    shadow_cfg.display_enable = value;
      REG_CURSOR_VISIBLE:    shadow_cfg.cursor_visible = value;
      REG_CURSOR_BLINK:      shadow_cfg.cursor_blink = value;
      REG_ADDRESS_INCREMENT: shadow_cfg.address_increment = value;
      default:               shadow_cfg.display_shift = value;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(display_cfg_t c);
    write_reg(REG_FOUR_BIT_BUS, c.four_bit_bus);
    write_reg(REG_TALL_FONT, c.tall_font);
    write_reg(REG_TWO_LINE_MODE, c.two_line_mode);
    write_reg(REG_DISPLAY_ENABLE, c.display_enable);
    write_reg(REG_CURSOR_VISIBLE, c.cursor_visible);
    write_reg(REG_CURSOR_BLINK, c.cursor_blink);
    write_reg(REG_ADDRESS_INCREMENT, c.address_increment);
    write_reg(REG_DISPLAY_SHIFT, c.display_shift);
  endtask

  // Sender pauses until every outstanding transaction has been checked
  task automatic wait_idle();
    do @(negedge clk);
    while (item_backlog.size() != 0 || s_tvalid || expected_pins.size() != 0);
  endtask

  function automatic bus_item_t make_item(cmd_t kind, logic [7:0] code, logic last,
                                          logic line_sel, logic [5:0] column);
    bus_item_t it;
    it.cmd = kind;
    it.char_code = code;
    it.last = last;
    it.line_sel = line_sel;
    it.column = column;
    return it;
  endfunction

  function automatic bus_item_t random_item(cmd_t kind);
    return make_item(kind, 8'($urandom), 1'($urandom), 1'($urandom),
                     6'($urandom_range(63)));
  endfunction

  // Bursts of requests (sometimes overflowing the FIFO) between runs of ticks
  function automatic void queue_random_traffic(int count);
    int   added;
    int   burst;
    cmd_t kind;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 30) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          case ($urandom_range(9))
            0:       kind = CMD_CLEAR;
            1, 2:    kind = CMD_POSITION;
            default: kind = CMD_WRITE;
          endcase
          item_backlog.push_back(random_item(kind));
        end
      end else begin
        burst = $urandom_range(1, 24);
        repeat (burst) item_backlog.push_back(random_item(CMD_TICK));
      end
      added += burst;
    end
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 38;
    stall_pct = 82;

    // 4-bit power-up with every bit flipped from its default
    load_config('{four_bit_bus: 1'b1, tall_font: 1'b1, two_line_mode: 1'b0,
                  display_enable: 1'b0, cursor_visible: 1'b1, cursor_blink: 1'b1,
                  address_increment: 1'b0, display_shift: 1'b1});
    // requests queued before the display is ready
    item_backlog.push_back(make_item(CMD_WRITE, 8'hFF, 1'b1, 1'b0, 6'd0));
    item_backlog.push_back(make_item(CMD_POSITION, 8'h00, 1'b0, 1'b1, 6'd63));
    item_backlog.push_back(make_item(CMD_CLEAR, 8'h00, 1'b1, 1'b1, 6'd63));
    item_backlog.push_back(make_item(CMD_WRITE, 8'h00, 1'b0, 1'b1, 6'd63));
    item_backlog.push_back(make_item(CMD_POSITION, 8'hFF, 1'b1, 1'b0, 6'd0));
    // four bytes of the five-byte sequence
    repeat (16) item_backlog.push_back(make_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 6'd0));
    wait_idle();

    // drop to 8-bit with the step past the shorter sequence, then start a byte
    write_reg(REG_FOUR_BIT_BUS, 1'b0);
    repeat (2) item_backlog.push_back(make_item(CMD_TICK, 8'hFF, 1'b1, 1'b1, 6'd63));
    wait_idle();

    // back to nibbles with the enable still high
    write_reg(REG_FOUR_BIT_BUS, 1'b1);
    repeat (2) item_backlog.push_back(make_item(CMD_TICK, 8'h00, 1'b0, 1'b0, 6'd0));
    queue_random_traffic(200);
    wait_idle();

    // all bits low, 8-bit bus; receiver mostly ready
    send_idle_pct = 82;
    stall_pct = 38;
    load_config('0);
    queue_random_traffic(200);
    wait_idle();

    // all bits high, full rate, with a long receiver hold-off up front
    send_idle_pct = 0;
    stall_pct = 0;
    load_config('1);
    hold_total = hold_total + 300;
    queue_random_traffic(200);
    wait_idle();
    repeat (4) @(posedge clk);

    $display("summary: %0d transactions in, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("summary: %0d requests queued, %0d refused on a full FIFO, %0d done pulses",
             req_taken, req_refused, done_pulses);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
